FILE: hdl/gcb_pkg.sv
// Shared types, codes and helpers for the greedy cluster balancer.
// Depends on nothing; gcb_cell, gcb_chain and the balancer unit import it.
package gcb_pkg;

	localparam int DEF_MAX_CLUSTERS = 64;
	localparam int DEF_MAX_NODES    = 16;
	localparam int KEY_W            = 64;
	localparam int CNT_W            = 32;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 7;

	localparam logic [1:0] ACT_HIT   = 2'd0;
	localparam logic [1:0] ACT_SIZE  = 2'd1;
	localparam logic [1:0] ACT_RUN   = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [1:0] MODE_RR   = 2'd0;
	localparam logic [1:0] MODE_SIZE = 2'd1;
	localparam logic [1:0] MODE_POP  = 2'd2;
	localparam logic [1:0] MODE_PROD = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NODES  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLUST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GCACHE = 3'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [5:0]  cluster_id;
		logic [31:0] list_size;
	} item_t;

	typedef struct packed {
		logic [5:0] out_cluster;
		logic [3:0] out_node;
		logic       is_global;
		logic       last;
	} result_t;

	// Control of the sorting chain: clear, insert one key, pop the head.
	typedef struct packed {
		logic clr;
		logic ins;
		logic pop;
	} sort_ctl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

FILE: hdl/gcb_ram.sv
// Generic single write port RAM with a registered read port.
// Depends on nothing.
module gcb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/gcb_cell.sv
// One cell of the insertion sorting chain: holds one key and cluster id.
// Depends on gcb_pkg.
module gcb_cell
	import gcb_pkg::*;
#(
	parameter int ID_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sort_ctl_t        ctl,
	input  logic [KEY_W-1:0] new_key,
	input  logic [ID_W-1:0]  new_id,
	input  logic             left_pass,
	input  logic             left_occ,
	input  logic [KEY_W-1:0] left_key,
	input  logic [ID_W-1:0]  left_id,
	input  logic             right_occ,
	input  logic [KEY_W-1:0] right_key,
	input  logic [ID_W-1:0]  right_id,
	output logic             pass,
	output logic             occ,
	output logic [KEY_W-1:0] key,
	output logic [ID_W-1:0]  id
);

	logic             occ_q;
	logic [KEY_W-1:0] key_q;
	logic [ID_W-1:0]  id_q;

	// An occupied cell whose key is not below the new one keeps its place (stable order).
	assign pass = occ_q && (key_q >= new_key);
	assign occ  = occ_q;
	assign key  = key_q;
	assign id   = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.clr) begin
			occ_q <= 1'b0;
		end else if (ctl.ins) begin
			if (!pass) begin
				occ_q <= left_pass ? 1'b1 : left_occ;
			end
		end else if (ctl.pop) begin
			occ_q <= right_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !pass) begin
			key_q <= left_pass ? new_key : left_key;
			id_q  <= left_pass ? new_id : left_id;
		end else if (ctl.pop) begin
			key_q <= right_key;
			id_q  <= right_id;
		end
	end

endmodule

FILE: hdl/gcb_chain.sv
// Row of sorting cells: keeps keys in descending order, head at cell zero.
// Depends on gcb_pkg and gcb_cell.
module gcb_chain
	import gcb_pkg::*;
#(
	parameter int CELLS = 64,
	parameter int ID_W  = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sort_ctl_t        ctl,
	input  logic [KEY_W-1:0] new_key,
	input  logic [ID_W-1:0]  new_id,
	output logic             head_occ,
	output logic [KEY_W-1:0] head_key,
	output logic [ID_W-1:0]  head_id
);

	logic             pass_w [CELLS+1];
	logic             occ_w  [CELLS+1];
	logic [KEY_W-1:0] key_w  [CELLS+1];
	logic [ID_W-1:0]  id_w   [CELLS+1];

	// Tails of the row: nothing stands left of the head, an empty slot right of the end.
	assign occ_w[CELLS]  = 1'b0;
	assign key_w[CELLS]  = '0;
	assign id_w[CELLS]   = '0;
	assign pass_w[CELLS] = 1'b0;

	for (genvar c = 0; c < CELLS; c++) begin : g_cell
		logic             lp;
		logic             lo;
		logic [KEY_W-1:0] lk;
		logic [ID_W-1:0]  li;
		if (c == 0) begin : g_head
			assign lp = 1'b1;
			assign lo = 1'b0;
			assign lk = '0;
			assign li = '0;
		end else begin : g_body
			assign lp = pass_w[c-1];
			assign lo = occ_w[c-1];
			assign lk = key_w[c-1];
			assign li = id_w[c-1];
		end
		gcb_cell #(.ID_W(ID_W)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_key   (new_key),
			.new_id    (new_id),
			.left_pass (lp),
			.left_occ  (lo),
			.left_key  (lk),
			.left_id   (li),
			.right_occ (occ_w[c+1]),
			.right_key (key_w[c+1]),
			.right_id  (id_w[c+1]),
			.pass      (pass_w[c]),
			.occ       (occ_w[c]),
			.key       (key_w[c]),
			.id        (id_w[c])
		);
	end

	assign head_occ = occ_w[0] | pass_w[CELLS];
	assign head_key = key_w[0];
	assign head_id  = id_w[0];

endmodule

FILE: hdl/greedy_cluster_balancer_unit.sv
// Greedy cluster balancer: per-cluster hit counts and sizes, balance by longest-first greedy.
// Hit: read, then write back; size load and clear: taken in idle, back to back. Balance: a pass
// that deals round robin or, in the greedy modes, fills the chain by key, zeroes the loads and
// places (node RAM scanned one node a cycle); then hit-count fill, global pops, result beats.
// Reset (arst_n, asynchronous) clears control state, config and hit valid bits; no sweep.
// Depends on gcb_pkg, gcb_ram and gcb_chain.
module greedy_cluster_balancer_unit
	import gcb_pkg::*;
#(
	parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
	parameter int MAX_NODES    = DEF_MAX_NODES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  item_t                 item,
	input  logic                  item_valid,
	output logic                  item_stall,
	output result_t               result,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CL_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int CLC_W = $clog2(MAX_CLUSTERS + 1);
	localparam int ND_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NDC_W = $clog2(MAX_NODES + 1);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_HIT_WR = 12'b0000_0000_0010,
		S_LOAD   = 12'b0000_0000_0100,
		S_NCLR   = 12'b0000_0000_1000,
		S_POP    = 12'b0000_0001_0000,
		S_SCAN   = 12'b0000_0010_0000,
		S_PUT    = 12'b0000_0100_0000,
		S_GLOAD  = 12'b0000_1000_0000,
		S_GPOP   = 12'b0001_0000_0000,
		S_ERD    = 12'b0010_0000_0000,
		S_ECAP   = 12'b0100_0000_0000,
		S_EOUT   = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [1:0] mode_q;
	logic [4:0] ncount_q;
	logic [6:0] ccount_q;
	logic [6:0] gcount_q;

	logic [NDC_W-1:0] nodes_eff;
	logic [CLC_W-1:0] cc_eff;
	logic [CLC_W-1:0] gc_eff;

	// Working registers
	logic [1:0]        key_mode_q;
	logic [CL_W-1:0]   hid_q;
	logic [CLC_W-1:0]  ld_cnt_q;
	logic [CLC_W-1:0]  pc_q;
	logic [CLC_W-1:0]  gp_q;
	logic [CLC_W-1:0]  e_cnt_q;
	logic [NDC_W-1:0]  k_q;
	logic [ND_W-1:0]   rr_q;
	logic [ND_W-1:0]   best_q;
	logic [KEY_W-1:0]  best_load_q;
	logic [KEY_W-1:0]  w_q;
	logic [CL_W-1:0]   id_q;
	logic              hv_q [MAX_CLUSTERS];

	logic              v_s1;
	logic [CL_W-1:0]   id_s1;
	logic              v_s2;
	logic [CL_W-1:0]   id_s2;
	logic [KEY_W-1:0]  w_s2;
	logic              sc_v_s1;
	logic [NDC_W-1:0]  sc_k_s1;

	result_t           res_q;
	logic              res_valid_q;

	// RAM ports
	logic              hit_we;
	logic [CL_W-1:0]   hit_waddr;
	logic [CNT_W-1:0]  hit_wdata;
	logic [CL_W-1:0]   hit_raddr;
	logic [CNT_W-1:0]  hit_rd;
	logic [CNT_W-1:0]  hit_eff;
	logic [CL_W-1:0]   hit_daddr;

	logic              size_we;
	logic [CNT_W-1:0]  size_rd;

	logic              node_we;
	logic [ND_W-1:0]   node_waddr;
	logic [KEY_W-1:0]  node_wdata;
	logic [KEY_W-1:0]  node_rd;

	logic              plc_we;
	logic [CL_W-1:0]   plc_waddr;
	logic [ND_W:0]     plc_wdata;
	logic [ND_W:0]     plc_rd;

	sort_ctl_t         sctl;
	logic              head_occ;
	logic [KEY_W-1:0]  head_key;
	logic [CL_W-1:0]   head_id;

	logic              accept;
	logic              id_ok;
	logic              issue;
	logic              load_done;
	logic              scan_issue;
	logic [KEY_W:0]    put_sum;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign id_ok        = (32'(item.cluster_id) < 32'(MAX_CLUSTERS));
	assign result       = res_q;
	assign result_valid = res_valid_q;

	// Clamp the configuration into the ranges the datapath handles
	always_comb begin
		if (ncount_q == '0) begin
			nodes_eff = NDC_W'(1);
		end else if (32'(ncount_q) > 32'(MAX_NODES)) begin
			nodes_eff = NDC_W'(MAX_NODES);
		end else begin
			nodes_eff = NDC_W'(ncount_q);
		end
		if (ccount_q == '0) begin
			cc_eff = CLC_W'(1);
		end else if (32'(ccount_q) > 32'(MAX_CLUSTERS)) begin
			cc_eff = CLC_W'(MAX_CLUSTERS);
		end else begin
			cc_eff = CLC_W'(ccount_q);
		end
		if (32'(gcount_q) > 32'(cc_eff)) begin
			gc_eff = cc_eff;
		end else begin
			gc_eff = CLC_W'(gcount_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RR;
			ncount_q <= 5'd1;
			ccount_q <= 7'd64;
			gcount_q <= 7'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[1:0];
				CFG_NODES:  ncount_q <= cfg_data[4:0];
				CFG_CLUST:  ccount_q <= cfg_data;
				CFG_GCACHE: gcount_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Hit counts: a miss on the valid bit reads as zero, so a clear drops every bit at once
	assign hit_raddr = (state_q == S_IDLE) ? CL_W'(item.cluster_id) : ld_cnt_q[CL_W-1:0];
	assign hit_daddr = (state_q == S_HIT_WR) ? hid_q : id_s1;
	assign hit_eff   = hv_q[hit_daddr] ? hit_rd : '0;
	assign hit_we    = (state_q == S_HIT_WR) ||
		(v_s1 && (state_q == S_LOAD) && (key_mode_q == MODE_RR));
	assign hit_waddr = hit_daddr;
	assign hit_wdata = sat_inc(hit_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_CLUSTERS; c++) begin
				hv_q[c] <= 1'b0;
			end
		end else if (accept && item.action == ACT_CLEAR) begin
			for (int c = 0; c < MAX_CLUSTERS; c++) begin
				hv_q[c] <= 1'b0;
			end
		end else if (hit_we) begin
			hv_q[hit_waddr] <= 1'b1;
		end
	end

	gcb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CLUSTERS)) u_hit_ram (
		.clk   (clk),
		.we    (hit_we),
		.waddr (hit_waddr),
		.wdata (hit_wdata),
		.raddr (hit_raddr),
		.rdata (hit_rd)
	);

	assign size_we = accept && (item.action == ACT_SIZE) && id_ok;

	gcb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_CLUSTERS)) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (CL_W'(item.cluster_id)),
		.wdata (item.list_size),
		.raddr (ld_cnt_q[CL_W-1:0]),
		.rdata (size_rd)
	);

	// Node loads: zeroed by a sweep at the start of greedy placement, then scanned per cluster
	assign put_sum    = {1'b0, best_load_q} + {1'b0, w_q};
	assign node_we    = ((state_q == S_NCLR) && (k_q < nodes_eff)) || (state_q == S_PUT);
	assign node_waddr = (state_q == S_PUT) ? best_q : k_q[ND_W-1:0];
	assign node_wdata = (state_q == S_PUT) ? (put_sum[KEY_W] ? '1 : put_sum[KEY_W-1:0]) : '0;
	assign scan_issue = (state_q == S_SCAN) && (k_q < nodes_eff);

	gcb_ram #(.WIDTH(KEY_W), .DEPTH(MAX_NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (k_q[ND_W-1:0]),
		.rdata (node_rd)
	);

	// Placement: top bit marks a global cluster
	always_comb begin
		plc_we    = 1'b0;
		plc_waddr = id_s1;
		plc_wdata = {1'b0, rr_q};
		if (v_s1 && (state_q == S_LOAD) && (key_mode_q == MODE_RR)) begin
			plc_we = 1'b1;
		end else if (state_q == S_PUT) begin
			plc_we    = 1'b1;
			plc_waddr = id_q;
			plc_wdata = {1'b0, best_q};
		end else if ((state_q == S_GPOP) && (gp_q < gc_eff)) begin
			plc_we    = 1'b1;
			plc_waddr = head_id;
			plc_wdata = {1'b1, {ND_W{1'b0}}};
		end
	end

	gcb_ram #(.WIDTH(ND_W + 1), .DEPTH(MAX_CLUSTERS)) u_plc_ram (
		.clk   (clk),
		.we    (plc_we),
		.waddr (plc_waddr),
		.wdata (plc_wdata),
		.raddr (e_cnt_q[CL_W-1:0]),
		.rdata (plc_rd)
	);

	// Sorting chain: cleared when a balance starts, fed from the weight stage,
	// drained from the head.
	assign sctl.clr = accept && (item.action == ACT_RUN);
	assign sctl.ins = v_s2;
	assign sctl.pop = ((state_q == S_POP) && (pc_q < cc_eff)) ||
		((state_q == S_GPOP) && (gp_q < gc_eff));

	gcb_chain #(.CELLS(MAX_CLUSTERS), .ID_W(CL_W)) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sctl),
		.new_key  (w_s2),
		.new_id   (id_s2),
		.head_occ (head_occ),
		.head_key (head_key),
		.head_id  (head_id)
	);

	// Fill pipeline: read address, then weight register, then insert
	assign issue     = ((state_q == S_LOAD) || (state_q == S_GLOAD)) && (ld_cnt_q < cc_eff);
	assign load_done = (ld_cnt_q == cc_eff) && !v_s1 && !v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			sc_v_s1 <= 1'b0;
		end else begin
			v_s1    <= issue;
			v_s2    <= v_s1 && (key_mode_q != MODE_RR);
			sc_v_s1 <= scan_issue;
		end
	end

	always_ff @(posedge clk) begin
		id_s1   <= ld_cnt_q[CL_W-1:0];
		id_s2   <= id_s1;
		sc_k_s1 <= k_q;
		case (key_mode_q)
			MODE_SIZE: w_s2 <= KEY_W'(size_rd);
			MODE_PROD: w_s2 <= KEY_W'(hit_eff) * KEY_W'(size_rd);
			default:   w_s2 <= KEY_W'(hit_eff);
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && item.action == ACT_HIT && id_ok) begin
						state_q <= S_HIT_WR;
					end else if (accept && item.action == ACT_RUN) begin
						state_q <= S_LOAD;
					end
				end
				S_HIT_WR: state_q <= S_IDLE;
				S_LOAD: begin
					if (load_done) begin
						state_q <= (key_mode_q == MODE_RR) ? S_GLOAD : S_NCLR;
					end
				end
				S_NCLR: begin
					if (k_q >= nodes_eff) begin
						state_q <= S_POP;
					end
				end
				S_POP: state_q <= (pc_q < cc_eff) ? S_SCAN : S_GLOAD;
				S_SCAN: begin
					if (sc_v_s1 && (sc_k_s1 == nodes_eff - 1'b1)) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: state_q <= S_POP;
				S_GLOAD: begin
					if (load_done) begin
						state_q <= S_GPOP;
					end
				end
				S_GPOP: begin
					if (gp_q >= gc_eff) begin
						state_q <= S_ERD;
					end
				end
				S_ERD: state_q <= S_ECAP;
				S_ECAP: begin
					state_q     <= S_EOUT;
					res_valid_q <= 1'b1;
				end
				S_EOUT: begin
					if (!result_stall) begin
						res_valid_q <= 1'b0;
						state_q     <= res_q.last ? S_IDLE : S_ERD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				hid_q      <= CL_W'(item.cluster_id);
				key_mode_q <= mode_q;
				ld_cnt_q   <= '0;
				rr_q       <= '0;
			end
			S_LOAD: begin
				if (issue) begin
					ld_cnt_q <= ld_cnt_q + 1'b1;
				end
				// Deal round robin: advance the node on each returned cluster
				if (v_s1 && key_mode_q == MODE_RR) begin
					rr_q <= (NDC_W'(rr_q) + 1'b1 == nodes_eff) ? '0 : rr_q + 1'b1;
				end
				k_q  <= '0;
				pc_q <= '0;
				if (load_done) begin
					ld_cnt_q   <= '0;
					key_mode_q <= MODE_POP;
				end
			end
			S_NCLR: begin
				k_q <= k_q + 1'b1;
			end
			S_POP: begin
				w_q  <= head_key;
				id_q <= head_id;
				k_q  <= '0;
				if (pc_q < cc_eff) begin
					pc_q <= pc_q + 1'b1;
				end else begin
					ld_cnt_q   <= '0;
					key_mode_q <= MODE_POP;
				end
			end
			S_SCAN: begin
				if (scan_issue) begin
					k_q <= k_q + 1'b1;
				end
				// Strict compare keeps the lowest node index on equal load
				if (sc_v_s1 && (sc_k_s1 == '0 || node_rd < best_load_q)) begin
					best_load_q <= node_rd;
					best_q      <= sc_k_s1[ND_W-1:0];
				end
			end
			S_GLOAD: begin
				if (issue) begin
					ld_cnt_q <= ld_cnt_q + 1'b1;
				end
				gp_q    <= '0;
				e_cnt_q <= '0;
			end
			S_GPOP: begin
				if (gp_q < gc_eff) begin
					gp_q <= gp_q + 1'b1;
				end
			end
			S_ECAP: begin
				res_q.out_cluster <= 6'(e_cnt_q);
				res_q.out_node    <= plc_rd[ND_W] ? 4'd0 : 4'(plc_rd[ND_W-1:0]);
				res_q.is_global   <= plc_rd[ND_W];
				res_q.last        <= (e_cnt_q + 1'b1 == cc_eff);
			end
			S_EOUT: begin
				if (!result_stall) begin
					e_cnt_q <= e_cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// A result beat is only ever shown while the sequencer waits on it
	a_res_in_eout: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> state_q == S_EOUT)
		else $error("result valid outside the output state");

	// Taking the last beat of a balance frees the input side
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && result.last) |=> state_q == S_IDLE)
		else $error("balance did not finish after its last beat");

	// The fill counter never runs past the cluster count
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD || state_q == S_GLOAD) |-> ld_cnt_q <= cc_eff)
		else $error("fill counter overran the cluster count");

	// Greedy placement always lands on a node in use
	a_put_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> NDC_W'(best_q) < nodes_eff)
		else $error("cluster placed on a node out of range");

	// Each popped cluster comes from an occupied head cell
	a_pop_occ: assert property (@(posedge clk) disable iff (!arst_n)
		sctl.pop |-> head_occ)
		else $error("pop from an empty sorting chain");

endmodule
